FILE: src/ptbt_pkg.sv
package ptbt_pkg;

    // command codes
    localparam logic [2:0] CMD_GET   = 3'd0;
    localparam logic [2:0] CMD_SET   = 3'd1;
    localparam logic [2:0] CMD_FILL  = 3'd2;
    localparam logic [2:0] CMD_CLEAR = 3'd3;
    localparam logic [2:0] CMD_SUM   = 3'd4;

    // register index as decoded from paddr[2]
    localparam logic REG_ROWS_IN_USE = 1'b0;

    localparam int ROW_BITS        = 64;
    localparam int ENTRY_BITS      = 2;
    localparam int ENTRIES_PER_ROW = 32;
    localparam int ROWSUM_W        = 7;
    localparam int SUM_W           = 13;

    localparam logic [SUM_W-1:0] SUM_MAX = 13'd8191;

    // control from the sequencer to the sum unit
    typedef struct packed {
        logic clr;
        logic vld;
    } acc_ctrl_t;

endpackage

FILE: src/ptbt_acc.sv
module ptbt_acc
    import ptbt_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  acc_ctrl_t           ctrl,
    input  logic [ROW_BITS-1:0] row_data,
    output logic [SUM_W-1:0]    sum,
    output logic                busy
);

    logic [ROWSUM_W-1:0] rs_reg;
    logic                rs_vld_reg;
    logic [SUM_W-1:0]    acc_reg;
    logic [SUM_W-1:0]    acc_next;
    logic [SUM_W:0]      acc_wide;

    // balanced adder tree over the 32 entries of one row
    function automatic logic [ROWSUM_W-1:0] row_sum(input logic [ROW_BITS-1:0] r);
        logic [2:0] l0 [16];
        logic [3:0] l1 [8];
        logic [4:0] l2 [4];
        logic [5:0] l3 [2];
        for (int i = 0; i < 16; i++) begin
            l0[i] = 3'(r[4*i +: 2]) + 3'(r[4*i+2 +: 2]);
        end
        for (int i = 0; i < 8; i++) begin
            l1[i] = 4'(l0[2*i]) + 4'(l0[2*i+1]);
        end
        for (int i = 0; i < 4; i++) begin
            l2[i] = 5'(l1[2*i]) + 5'(l1[2*i+1]);
        end
        for (int i = 0; i < 2; i++) begin
            l3[i] = 6'(l2[2*i]) + 6'(l2[2*i+1]);
        end
        return 7'(l3[0]) + 7'(l3[1]);
    endfunction

    // saturating accumulate
    always_comb begin
        acc_wide = {1'b0, acc_reg} + (SUM_W+1)'(rs_reg);
        if (acc_wide > {1'b0, SUM_MAX}) begin
            acc_next = SUM_MAX;
        end else begin
            acc_next = acc_wide[SUM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rs_vld_reg <= 1'b0;
            acc_reg    <= '0;
        end else begin
            rs_vld_reg <= ctrl.vld;
            if (ctrl.clr) begin
                acc_reg <= '0;
            end else if (rs_vld_reg) begin
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rs_reg <= row_sum(row_data);
    end

    assign sum  = acc_reg;
    assign busy = rs_vld_reg;

endmodule

FILE: src/packed_two_bit_table_unit.sv
// packed two-bit table: MAX_ROWS rows of 64 bits, each row holding 32 two-bit
// entries (entry c in bits 2c+1..2c), kept in a single-port-write,
// registered-read memory. rows_in_use (apb address 0, reset 64, limited to
// MAX_ROWS) sets how many rows from row 0 are active. commands on s_tdata:
// get, set (replaces the entry), fill, clear and sum; every item gives
// exactly one result item on m_tdata. a get or set with a row at or beyond
// the active count or a column above 31 changes nothing and returns status 1.
// the sum saturates at 8191. codes 5 to 7 return an all-zero result.
// timing: one item at a time, s_tready is high only while idle. a get or set
// goes through memory read, modify or select, and result; fill, clear and sum
// walk the n active rows, the memory gives one row per cycle and sets the pace
// of the row walk, the sum runs through a two-stage adder tree and accumulator
// and then drains. an out-of-range get or set, an empty table walk or an
// unknown code goes straight to the result. after reset the memory is zeroed
// by a pass over all MAX_ROWS rows, during which no item is accepted; apb
// writes are taken at any time.
module packed_two_bit_table_unit
    import ptbt_pkg::*;
#(
    parameter int MAX_ROWS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // cmd[2:0], row_index[9:3], column_index[15:10],
                                   // entry_value[17:16], zero fill above
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // read_value[1:0], entry_sum[14:2], status[15]
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // row address width and a count width that holds MAX_ROWS and any rows_in_use
    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = (AW + 1 > 7) ? AW + 1 : 7;

    // sequencer states
    localparam logic [2:0] ST_INIT  = 3'd0;  // zeroing pass after reset
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;  // read the addressed row
    localparam logic [2:0] ST_USE   = 3'd3;  // select entry or write back modified row
    localparam logic [2:0] ST_WALK  = 3'd4;  // one active row per cycle
    localparam logic [2:0] ST_DRAIN = 3'd5;  // let the sum pipeline empty
    localparam logic [2:0] ST_DONE  = 3'd6;  // hand result to the output register

    // input fields
    logic [2:0] s_cmd;
    logic [6:0] s_row;
    logic [5:0] s_col;
    logic [1:0] s_val;

    assign s_cmd = s_tdata[2:0];
    assign s_row = s_tdata[9:3];
    assign s_col = s_tdata[15:10];
    assign s_val = s_tdata[17:16];

    logic s_accept;
    logic cfg_write;

    // control state
    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] walk_reg, walk_next;
    logic [CW-1:0] walk_inc;
    logic          rd_vld_reg, rd_vld_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [6:0]    rows_in_use_reg;

    // item payload captured at accept
    logic [2:0]    cmd_reg;
    logic [AW-1:0] row_reg;
    logic [4:0]    col_reg;
    logic [1:0]    val_reg;
    logic [CW-1:0] n_reg;

    // result
    logic [1:0]       res_read_reg, res_read_next;
    logic [SUM_W-1:0] res_sum_reg, res_sum_next;
    logic             res_status_reg, res_status_next;
    logic [15:0]      m_tdata_reg, m_tdata_next;

    // memory
    logic [ROW_BITS-1:0] mem [MAX_ROWS];
    logic [ROW_BITS-1:0] rd_data_reg;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [AW-1:0]       mem_raddr;
    logic [ROW_BITS-1:0] mem_wdata;

    // derived
    logic [CW-1:0]       n_cur;
    logic [CW-1:0]       row_ext;
    logic                out_of_range;
    logic [5:0]          bit_sh;
    logic [ROW_BITS-1:0] entry_mask;
    logic [ROW_BITS-1:0] entry_shifted;

    // sum unit
    acc_ctrl_t        acc_ctrl;
    logic [SUM_W-1:0] acc_sum;
    logic             acc_busy;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_write = psel && penable && pwrite && pready;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ROWS_IN_USE) ? {25'b0, rows_in_use_reg} : 32'b0;

    // active rows, limited to the store depth
    assign n_cur = (CW'(rows_in_use_reg) > CW'(MAX_ROWS)) ? CW'(MAX_ROWS)
                                                          : CW'(rows_in_use_reg);
    assign row_ext      = CW'(s_row);
    assign out_of_range = (row_ext >= n_cur) || s_col[5];

    assign walk_inc      = walk_reg + 1'b1;
    assign bit_sh        = {col_reg, 1'b0};
    assign entry_mask    = ROW_BITS'(2'b11) << bit_sh;
    assign entry_shifted = ROW_BITS'(val_reg) << bit_sh;

    always_comb begin
        state_next      = state_reg;
        walk_next       = walk_reg;
        rd_vld_next     = 1'b0;
        res_read_next   = res_read_reg;
        res_sum_next    = res_sum_reg;
        res_status_next = res_status_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        mem_we          = 1'b0;
        mem_waddr       = walk_reg[AW-1:0];
        mem_wdata       = '0;
        mem_raddr       = walk_reg[AW-1:0];
        acc_ctrl.clr    = 1'b0;
        acc_ctrl.vld    = rd_vld_reg;

        case (state_reg)
            ST_INIT: begin
                mem_we    = 1'b1;
                walk_next = walk_inc;
                if (walk_inc == CW'(MAX_ROWS)) begin
                    walk_next  = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    res_read_next   = '0;
                    res_sum_next    = '0;
                    res_status_next = 1'b0;
                    walk_next       = '0;
                    acc_ctrl.clr    = 1'b1;
                    case (s_cmd)
                        CMD_GET, CMD_SET: begin
                            if (out_of_range) begin
                                res_status_next = 1'b1;
                                state_next      = ST_DONE;
                            end else begin
                                state_next = ST_READ;
                            end
                        end
                        CMD_FILL, CMD_CLEAR, CMD_SUM: begin
                            // nothing to walk when no row is active
                            state_next = (n_cur == '0) ? ST_DONE : ST_WALK;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_READ: begin
                mem_raddr  = row_reg;
                state_next = ST_USE;
            end
            ST_USE: begin
                if (cmd_reg == CMD_GET) begin
                    res_read_next = rd_data_reg[bit_sh +: ENTRY_BITS];
                end else begin
                    // set replaces the entry
                    mem_we    = 1'b1;
                    mem_waddr = row_reg;
                    mem_wdata = (rd_data_reg & ~entry_mask) | entry_shifted;
                end
                state_next = ST_DONE;
            end
            ST_WALK: begin
                if (cmd_reg == CMD_SUM) begin
                    rd_vld_next = 1'b1;
                end else begin
                    mem_we    = 1'b1;
                    mem_wdata = (cmd_reg == CMD_FILL) ? {ENTRIES_PER_ROW{val_reg}} : '0;
                end
                walk_next = walk_inc;
                if (walk_inc == n_reg) begin
                    state_next = (cmd_reg == CMD_SUM) ? ST_DRAIN : ST_DONE;
                end
            end
            ST_DRAIN: begin
                if (!rd_vld_reg && !acc_busy) begin
                    res_sum_next = acc_sum;
                    state_next   = ST_DONE;
                end
            end
            ST_DONE: begin
                // wait for the output register to free up
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {res_status_reg, res_sum_reg, res_read_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_INIT;
            walk_reg        <= '0;
            rd_vld_reg      <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            rows_in_use_reg <= 7'd64;
        end else begin
            state_reg    <= state_next;
            walk_reg     <= walk_next;
            rd_vld_reg   <= rd_vld_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_write && (paddr[2] == REG_ROWS_IN_USE)) begin
                rows_in_use_reg <= pwdata[6:0];
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg <= s_cmd;
            row_reg <= row_ext[AW-1:0];
            col_reg <= s_col[4:0];
            val_reg <= s_val;
            n_reg   <= n_cur;
        end
        res_read_reg   <= res_read_next;
        res_sum_reg    <= res_sum_next;
        res_status_reg <= res_status_next;
        m_tdata_reg    <= m_tdata_next;
    end

    // row store
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    ptbt_acc u_acc (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (acc_ctrl),
        .row_data (rd_data_reg),
        .sum      (acc_sum),
        .busy     (acc_busy)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: src/ptbt_checker.sv
module ptbt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // an accepted item keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted in back-to-back cycles");

    // the zeroing pass holds off input right after reset
    a_init_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> !s_tready)
        else $error("input ready before the store was cleared");

    // a new result is produced only after the sequencer left idle
    a_result_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared while the block was idle");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed under stall");

endmodule

bind packed_two_bit_table_unit ptbt_checker u_ptbt_checker (.*);
